[src/csq_pkg.sv]
`timescale 1ns / 1ps
// package for the counting semaphore wait queue unit
// holds the request kind and status codes and fixed field widths; no dependencies

package csq_pkg;

  localparam int unsigned CNT_W      = 16;
  localparam int unsigned RID_W      = 8;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned IN_DATA_W  = 32;
  localparam int unsigned OUT_DATA_W = 48;

  localparam logic [CNT_W-1:0] CAP_BINARY       = 16'd1;
  localparam logic [CNT_W-1:0] CAP_MIN_COUNTING = 16'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INITIAL_CAPACITY = 1'b0,
    CFG_INITIAL_UNITS    = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    KIND_TAKE        = 2'd0,
    KIND_GIVE        = 2'd1,
    KIND_TO_BINARY   = 2'd2,
    KIND_TO_COUNTING = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_UNAVAILABLE = 3'd1,
    ST_QUEUED      = 3'd2,
    ST_BUSY        = 3'd3,
    ST_INVALID     = 3'd4,
    ST_NOTSUPP     = 3'd5,
    ST_QFULL       = 3'd6
  } status_e;

endpackage

[src/counting_semaphore_wait_queue_unit.sv]
`timescale 1ns / 1ps
// counting semaphore with a fifo of waiting requester ids
// depends on csq_pkg for codes and field widths
//
// usage:
//   the slave stream carries one request per transaction: tuser holds the
//   kind (take, give, convert to binary, convert to counting), tdata the
//   requester id, may_wait, has_context and new_capacity. the master stream
//   returns exactly one result per request: status, woken flag and id, and
//   the count and capacity after the request.
//   a request is registered on acceptance and resolved into the result
//   register once the master side can take a new result; one request per
//   cycle is sustained while the master side does not stall. the pace is
//   set by the count and queue pointer update, done once per request.
//   the waiter ids live in a WAIT_DEPTH entry memory; the id at the queue
//   head is kept read out in a register so a give can report it at once.
//   reset loads capacity 1 and count 1 and empties the queue; a register
//   write reloads capacity and count from the registers the same way.
//   when the master side stalls the result holds, one more request may sit
//   in the input register, and tready drops until the result is taken.

module counting_semaphore_wait_queue_unit #(
  parameter int unsigned WAIT_DEPTH = 16,
  parameter int unsigned ID_WIDTH   = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,

  input  logic                              cfg_we_i,
  input  logic [csq_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [csq_pkg::CNT_W-1:0]         cfg_wdata_i,

  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // requester_id[7:0], may_wait[8], has_context[9], new_capacity[25:10], zero pad
  input  logic [csq_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // kind[1:0]
  input  logic [1:0]                        s_axis_tuser,

  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // status[2:0], woken_valid[3], woken_id[11:4], units_now[27:12],
  // capacity_now[43:28], zero pad
  output logic [csq_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);

  localparam int unsigned HW = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
  localparam int unsigned FW = $clog2(WAIT_DEPTH + 1);

  logic [csq_pkg::CNT_W-1:0] init_cap_q, init_cap_d;
  logic [csq_pkg::CNT_W-1:0] init_units_q, init_units_d;
  logic [csq_pkg::CNT_W-1:0] cap_q, cap_d;
  logic [csq_pkg::CNT_W-1:0] units_q, units_d;
  logic [HW-1:0]             head_q, head_d;
  logic [FW-1:0]             fill_q, fill_d;

  logic                      in_valid_q;
  logic [csq_pkg::IN_DATA_W-1:0] in_data_q;
  csq_pkg::kind_e            in_kind_q;

  logic                      out_valid_q;
  logic [csq_pkg::OUT_DATA_W-1:0] out_data_q, out_data_d;

  logic [ID_WIDTH-1:0]       mem_q [WAIT_DEPTH];
  logic [ID_WIDTH-1:0]       rd_q;

  logic                      proc;
  logic                      push, pop;
  logic [HW:0]               tail_sum;
  logic [HW-1:0]             tail;
  logic [15:0]               rid_ext;
  logic [15:0]               rd_ext;
  logic [ID_WIDTH-1:0]       wr_data;
  logic [csq_pkg::CNT_W-1:0] load_cap, load_units;

  logic [csq_pkg::RID_W-1:0] f_rid;
  logic                      f_may_wait;
  logic                      f_has_ctx;
  logic [csq_pkg::CNT_W-1:0] f_newcap;

  csq_pkg::status_e          status;
  logic                      woken_valid;
  logic [csq_pkg::RID_W-1:0] woken_id;
  logic [csq_pkg::CNT_W-1:0] units_n, cap_n;

  assign proc          = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || proc;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  assign f_rid      = in_data_q[7:0];
  assign f_may_wait = in_data_q[8];
  assign f_has_ctx  = in_data_q[9];
  assign f_newcap   = in_data_q[25:10];

  assign rid_ext  = {8'b0, f_rid};
  assign wr_data  = rid_ext[ID_WIDTH-1:0];
  assign rd_ext   = 16'(rd_q);
  assign tail_sum = {1'b0, head_q} + (HW+1)'(fill_q);
  assign tail     = (tail_sum >= (HW+1)'(WAIT_DEPTH)) ?
                    HW'(tail_sum - (HW+1)'(WAIT_DEPTH)) : tail_sum[HW-1:0];

  // register values after a write, and the state they load
  always_comb begin
    init_cap_d   = init_cap_q;
    init_units_d = init_units_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        csq_pkg::CFG_INITIAL_CAPACITY: init_cap_d   = cfg_wdata_i;
        csq_pkg::CFG_INITIAL_UNITS:    init_units_d = cfg_wdata_i;
        default: ;
      endcase
    end
    load_cap   = (init_cap_d == '0) ? csq_pkg::CAP_BINARY : init_cap_d;
    load_units = (init_units_d > load_cap) ? load_cap : init_units_d;
  end

  always_comb begin
    status      = csq_pkg::ST_OK;
    woken_valid = 1'b0;
    units_n     = units_q;
    cap_n       = cap_q;
    push        = 1'b0;
    pop         = 1'b0;
    case (in_kind_q)
      csq_pkg::KIND_TAKE: begin
        if (units_q != '0) begin
          units_n = units_q - 16'd1;
        end else if (!f_may_wait) begin
          status = csq_pkg::ST_UNAVAILABLE;
        end else if (!f_has_ctx) begin
          status = csq_pkg::ST_INVALID;
        end else if (fill_q == FW'(WAIT_DEPTH)) begin
          status = csq_pkg::ST_QFULL;
        end else begin
          push   = 1'b1;
          status = csq_pkg::ST_QUEUED;
        end
      end
      csq_pkg::KIND_GIVE: begin
        if (fill_q != '0) begin
          pop         = 1'b1;
          woken_valid = 1'b1;
        end else if (units_q >= cap_q) begin
          status = csq_pkg::ST_BUSY;
        end else begin
          units_n = units_q + 16'd1;
        end
      end
      csq_pkg::KIND_TO_BINARY: begin
        if (units_q != cap_q || fill_q != '0) begin
          status = csq_pkg::ST_BUSY;
        end else begin
          cap_n   = csq_pkg::CAP_BINARY;
          units_n = csq_pkg::CAP_BINARY;
        end
      end
      csq_pkg::KIND_TO_COUNTING: begin
        if (f_newcap < csq_pkg::CAP_MIN_COUNTING) begin
          status = csq_pkg::ST_INVALID;
        end else if (cap_q != csq_pkg::CAP_BINARY) begin
          status = csq_pkg::ST_NOTSUPP;
        end else begin
          cap_n = f_newcap;
        end
      end
      default: ;
    endcase
    woken_id   = woken_valid ? rd_ext[7:0] : '0;
    out_data_d = {4'b0, cap_n, units_n, woken_id, woken_valid, status};
  end

  always_comb begin
    cap_d   = cap_q;
    units_d = units_q;
    head_d  = head_q;
    fill_d  = fill_q;
    if (cfg_we_i) begin
      cap_d   = load_cap;
      units_d = load_units;
      head_d  = '0;
      fill_d  = '0;
    end else if (proc) begin
      cap_d   = cap_n;
      units_d = units_n;
      if (push) begin
        fill_d = fill_q + FW'(1);
      end
      if (pop) begin
        fill_d = fill_q - FW'(1);
        head_d = (head_q == HW'(WAIT_DEPTH - 1)) ? '0 : head_q + HW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_cap_q   <= csq_pkg::CAP_BINARY;
      init_units_q <= csq_pkg::CAP_BINARY;
      cap_q        <= csq_pkg::CAP_BINARY;
      units_q      <= csq_pkg::CAP_BINARY;
      head_q       <= '0;
      fill_q       <= '0;
      in_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      init_cap_q   <= init_cap_d;
      init_units_q <= init_units_d;
      cap_q        <= cap_d;
      units_q      <= units_d;
      head_q       <= head_d;
      fill_q       <= fill_d;
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (proc) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_data_q <= s_axis_tdata;
      in_kind_q <= csq_pkg::kind_e'(s_axis_tuser);
    end
    if (proc) begin
      out_data_q <= out_data_d;
    end
  end

  // waiter memory, head entry kept read out with write bypass
  always_ff @(posedge clk_i) begin
    if (proc && push && !cfg_we_i) begin
      mem_q[tail] <= wr_data;
    end
    if (proc && push && !cfg_we_i && tail == head_d) begin
      rd_q <= wr_data;
    end else begin
      rd_q <= mem_q[head_d];
    end
  end

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FW'(WAIT_DEPTH))
    else $error("wait queue fill above depth");

  a_units_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    units_q <= cap_q && cap_q != '0)
    else $error("count above capacity or zero capacity");

  a_woken_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_data_q[3] |-> out_data_q[2:0] == csq_pkg::ST_OK)
    else $error("woken waiter with non-ok status");

  a_pop_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc && pop && !cfg_we_i |=> fill_q == $past(fill_q) - FW'(1))
    else $error("give to waiter did not shrink queue");

  a_units_with_waiters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q != '0 |-> units_q == '0)
    else $error("waiters queued while units available");

endmodule
